// ----- rtl/tbps_pkg.sv -----
package tbps_pkg;

    localparam int WAIT_DEPTH  = 64;
    localparam int READY_DEPTH = 64;

    localparam int W_AW = $clog2(WAIT_DEPTH);
    localparam int W_CW = $clog2(WAIT_DEPTH + 1);
    localparam int R_AW = $clog2(READY_DEPTH);
    localparam int R_CW = $clog2(READY_DEPTH + 1);

    localparam int ID_W   = 16;
    localparam int NEED_W = 16;
    localparam int TIME_W = 24;
    localparam int CNT_W  = 7;

    localparam logic [15:0] DEPTH_RESET = 16'd10;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ARRIVE = 2'd1,
        CMD_TAKE   = 2'd2
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [NEED_W-1:0] need;
        logic [TIME_W-1:0] stime;
    } t_wait_entry;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stime;
    } t_rdy_entry;

endpackage

// ----- rtl/token_bucket_packet_shaper.sv -----
// Token bucket shaper with a waiting queue and a ready queue, each held in a
// synchronous RAM. A command is taken when start is high and busy is low; the
// queue heads are read from the RAMs in that cycle, and the bucket and queues
// are then updated and written back in ST_EXEC, with busy high. The result
// word is shown for exactly one cycle on o_strobe, in the cycle after the
// update, and the next command can be taken in that same cycle. The receiver
// cannot stall the result: it must take every word. The bucket depth register
// may be written whenever no command is in flight.
module token_bucket_packet_shaper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_tokens_needed,
    input  logic [23:0] i_service_time,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic        o_token_added,
    output logic        o_token_lost,
    output logic        o_packet_rejected,
    output logic        o_overflow_drop,
    output logic        o_moved,
    output logic [15:0] o_moved_id,
    output logic        o_served,
    output logic [15:0] o_served_id,
    output logic [23:0] o_served_time,
    output logic [15:0] o_bucket_level,
    output logic [6:0]  o_waiting_count,
    output logic [6:0]  o_ready_count
);
    import tbps_pkg::*;

    t_state r_state, n_state;

    logic [15:0] r_depth;
    logic [15:0] r_tokens, n_tokens;
    logic [15:0] r_arrival, n_arrival;

    logic [W_AW-1:0] r_wait_head, n_wait_head;
    logic [W_AW-1:0] r_wait_tail, n_wait_tail;
    logic [W_CW-1:0] r_wait_count, n_wait_count;
    logic [R_AW-1:0] r_rdy_head, n_rdy_head;
    logic [R_AW-1:0] r_rdy_tail, n_rdy_tail;
    logic [R_CW-1:0] r_rdy_count, n_rdy_count;

    t_wait_entry r_wait_mem [WAIT_DEPTH];
    t_rdy_entry  r_rdy_mem  [READY_DEPTH];
    t_wait_entry r_wait_rd;
    t_rdy_entry  r_rdy_rd;

    logic [1:0]        r_cmd;
    logic [NEED_W-1:0] r_need;
    logic [TIME_W-1:0] r_stime;

    logic        accept;
    logic        exec;
    logic        wait_we;
    t_wait_entry wait_wdata;
    logic        rdy_we;
    t_rdy_entry  rdy_wdata;
    t_wait_entry head;
    logic [15:0] level;
    logic [W_CW-1:0] wait_cnt_app;
    logic        try_move;

    logic n_added, n_lost, n_rejected, n_ovf, n_moved, n_served;
    logic [15:0] n_moved_id, n_served_id;
    logic [23:0] n_served_time;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        busy = 1'b0;
        exec = 1'b0;
        case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_EXEC: begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    // Update step; the heads were read from the RAMs in the accept cycle.
    always_comb begin
        n_tokens      = r_tokens;
        n_arrival     = r_arrival;
        n_wait_head   = r_wait_head;
        n_wait_tail   = r_wait_tail;
        n_wait_count  = r_wait_count;
        n_rdy_head    = r_rdy_head;
        n_rdy_tail    = r_rdy_tail;
        n_rdy_count   = r_rdy_count;
        n_added       = 1'b0;
        n_lost        = 1'b0;
        n_rejected    = 1'b0;
        n_ovf         = 1'b0;
        n_moved       = 1'b0;
        n_moved_id    = '0;
        n_served      = 1'b0;
        n_served_id   = '0;
        n_served_time = '0;
        wait_we       = 1'b0;
        rdy_we        = 1'b0;
        try_move      = 1'b0;
        level         = r_tokens;
        wait_cnt_app  = r_wait_count;
        wait_wdata    = '{id: n_arrival, need: r_need, stime: r_stime};
        rdy_wdata     = '{id: r_wait_rd.id, stime: r_wait_rd.stime};

        case (r_cmd)
            CMD_TICK: begin
                try_move = 1'b1;
                if (r_tokens < r_depth) begin
                    level   = r_tokens + 16'd1;
                    n_added = 1'b1;
                end else begin
                    n_lost = 1'b1;
                end
            end
            CMD_ARRIVE: begin
                n_arrival  = r_arrival + 16'd1;
                wait_wdata = '{id: n_arrival, need: r_need, stime: r_stime};
                if (r_need > r_depth) begin
                    n_rejected = 1'b1;
                end else begin
                    try_move = 1'b1;
                    if (r_wait_count == W_CW'(WAIT_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        wait_we      = 1'b1;
                        wait_cnt_app = r_wait_count + W_CW'(1);
                        n_wait_tail  = (r_wait_tail == W_AW'(WAIT_DEPTH - 1)) ?
                                       '0 : r_wait_tail + W_AW'(1);
                    end
                end
            end
            CMD_TAKE: begin
                if (r_rdy_count != '0) begin
                    n_served      = 1'b1;
                    n_served_id   = r_rdy_rd.id;
                    n_served_time = r_rdy_rd.stime;
                    n_rdy_head    = (r_rdy_head == R_AW'(READY_DEPTH - 1)) ?
                                    '0 : r_rdy_head + R_AW'(1);
                    n_rdy_count   = r_rdy_count - R_CW'(1);
                end
            end
            default: begin
            end
        endcase

        // An entry appended to an empty queue is its own head: forward it.
        head = (r_wait_count == '0) ? wait_wdata : r_wait_rd;
        n_tokens     = level;
        n_wait_count = wait_cnt_app;

        if (try_move && wait_cnt_app != '0 && r_rdy_count != R_CW'(READY_DEPTH)
            && head.need <= level) begin
            n_moved      = 1'b1;
            n_moved_id   = head.id;
            n_tokens     = level - head.need;
            rdy_we       = 1'b1;
            rdy_wdata    = '{id: head.id, stime: head.stime};
            n_rdy_tail   = (r_rdy_tail == R_AW'(READY_DEPTH - 1)) ?
                           '0 : r_rdy_tail + R_AW'(1);
            n_rdy_count  = r_rdy_count + R_CW'(1);
            n_wait_head  = (r_wait_head == W_AW'(WAIT_DEPTH - 1)) ?
                           '0 : r_wait_head + W_AW'(1);
            n_wait_count = wait_cnt_app - W_CW'(1);
        end
    end

    // Queue RAMs.
    always_ff @(posedge i_clk) begin
        if (exec && wait_we) begin
            r_wait_mem[r_wait_tail] <= wait_wdata;
        end
        r_wait_rd <= r_wait_mem[r_wait_head];
    end

    always_ff @(posedge i_clk) begin
        if (exec && rdy_we) begin
            r_rdy_mem[r_rdy_tail] <= rdy_wdata;
        end
        r_rdy_rd <= r_rdy_mem[r_rdy_head];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_command;
            r_need  <= i_tokens_needed;
            r_stime <= i_service_time;
        end
        if (exec) begin
            o_token_added     <= n_added;
            o_token_lost      <= n_lost;
            o_packet_rejected <= n_rejected;
            o_overflow_drop   <= n_ovf;
            o_moved           <= n_moved;
            o_moved_id        <= n_moved_id;
            o_served          <= n_served;
            o_served_id       <= n_served_id;
            o_served_time     <= n_served_time;
            o_bucket_level    <= n_tokens;
            o_waiting_count   <= CNT_W'(n_wait_count);
            o_ready_count     <= CNT_W'(n_rdy_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_depth      <= DEPTH_RESET;
            r_tokens     <= '0;
            r_arrival    <= '0;
            r_wait_head  <= '0;
            r_wait_tail  <= '0;
            r_wait_count <= '0;
            r_rdy_head   <= '0;
            r_rdy_tail   <= '0;
            r_rdy_count  <= '0;
            o_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= exec;
            if (i_cfg_valid && o_cfg_ready) begin
                r_depth <= i_cfg_data;
            end
            if (exec) begin
                r_tokens     <= n_tokens;
                r_arrival    <= n_arrival;
                r_wait_head  <= n_wait_head;
                r_wait_tail  <= n_wait_tail;
                r_wait_count <= n_wait_count;
                r_rdy_head   <= n_rdy_head;
                r_rdy_tail   <= n_rdy_tail;
                r_rdy_count  <= n_rdy_count;
            end
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not start an update");

    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe && !busy)
        else $error("update did not produce exactly one result word");

    a_move_or_serve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_moved && o_served))
        else $error("a packet was moved and served in the same step");

    a_move_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_moved) |-> o_ready_count != '0)
        else $error("moved packet missing from ready queue count");

endmodule
